[sv/ass_pkg.sv]
// Package with payload types and constants for the activation sparsity statistics block.
`timescale 1ns / 1ps
`default_nettype none
package ass_pkg;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 26;
    localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SQRT_OF_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECIP_SQRT = 2'd2;
    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic [0:0] KIND_ELEMENT = 1'b0;
    localparam logic [0:0] KIND_CLEAR = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [15:0] element_value;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic [16:0] sample_sparsity;
        logic [16:0] sample_active;
        logic        sample_quiet;
        logic [47:0] sparsity_total;
        logic [47:0] active_total;
        logic [31:0] quiet_total;
        logic [31:0] sample_total;
    } t_out_item;

    // One finished sample (or a clear) handed from the front to the back.
    typedef struct packed {
        logic        clear;
        logic [31:0] abs_sum;
        logic [46:0] square_sum;
        logic [16:0] positive_count;
    } t_job;
endpackage
`default_nettype wire

[sv/ass_front.sv]
// Front part: accumulates per-sample sums and emits one job per sample end or clear.
`timescale 1ns / 1ps
`default_nettype none
module ass_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire ass_pkg::t_in_item i_item,
    output logic                  o_job_valid,
    output ass_pkg::t_job         o_job
);
    import ass_pkg::*;

    logic [31:0] r_abs, n_abs;
    logic [46:0] r_sq, n_sq;
    logic [16:0] r_pos, n_pos;
    logic        neg;
    logic [15:0] mag;
    logic [32:0] abs_add;
    logic [47:0] sq_add;
    logic [31:0] mag_sq;

    always_comb begin
        neg = i_item.element_value[15];
        mag = neg ? (16'd0 - i_item.element_value) : i_item.element_value;
        mag_sq = {16'd0, mag} * {16'd0, mag};
        abs_add = {1'b0, r_abs} + {17'd0, mag};
        sq_add = {1'b0, r_sq} + {16'd0, mag_sq};
        n_abs = abs_add[32] ? 32'hFFFF_FFFF : abs_add[31:0];
        n_sq = sq_add[47] ? {47{1'b1}} : sq_add[46:0];
        n_pos = r_pos;
        if (!neg && mag != 16'd0 && r_pos != {17{1'b1}}) begin
            n_pos = r_pos + 17'd1;
        end
        o_job.clear = (i_item.kind == KIND_CLEAR);
        o_job.abs_sum = n_abs;
        o_job.square_sum = n_sq;
        o_job.positive_count = n_pos;
        o_job_valid = i_valid && (o_job.clear || i_item.last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abs <= '0;
            r_sq <= '0;
            r_pos <= '0;
        end else if (i_valid && i_item.kind == KIND_ELEMENT) begin
            if (i_item.last) begin
                r_abs <= '0;
                r_sq <= '0;
                r_pos <= '0;
            end else begin
                r_abs <= n_abs;
                r_sq <= n_sq;
                r_pos <= n_pos;
            end
        end
    end
endmodule
`default_nettype wire

[sv/ass_queue.sv]
// Small register queue between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module ass_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ass_pkg::t_job i_data,
    output logic               o_full,
    output logic               o_empty,
    input  wire logic          i_pop,
    output ass_pkg::t_job      o_data
);
    import ass_pkg::*;
    localparam int AW = $clog2(DEPTH);

    t_job           r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;
    logic           do_push, do_pop;

    assign o_full = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end
endmodule
`default_nettype wire

[sv/ass_back.sv]
// Back part: square root, division, sparsity and saturating totals, one job at a time.
`timescale 1ns / 1ps
`default_nettype none
module ass_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_job_valid,
    input  wire ass_pkg::t_job    i_job,
    output logic                  o_job_pop,
    input  wire logic [24:0]      i_sqrt_n,
    input  wire logic [25:0]      i_recip,
    output logic                  o_empty,
    input  wire logic             i_pop,
    output ass_pkg::t_out_item    o_item
);
    import ass_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQRT = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_TOT  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]  r_st;
    logic [5:0]  r_cnt;
    t_job        r_job;
    // Square root of square_sum << 16, zero-extended to 64 bits, two bits per cycle.
    logic [63:0] r_rem;
    logic [31:0] r_root;
    logic [63:0] r_rad;
    // Restoring division abs_sum << 24 by root, one quotient bit per cycle.
    logic [55:0] r_dvd;
    logic [32:0] r_drem;
    logic [55:0] r_quo;
    logic [16:0] r_sp;
    logic [50:0] r_prod;
    logic [47:0] r_sp_acc, r_act_acc;
    logic [31:0] r_q_acc, r_s_acc;
    logic        r_full;
    t_out_item   r_out;

    logic [63:0] trial_rem;
    logic [33:0] trial;
    logic [32:0] drem_sh;
    logic [55:0] ratio;
    logic [24:0] d;
    logic [48:0] sp_add;
    logic [48:0] act_add;
    logic        quiet;
    logic        load_out;

    always_comb begin
        trial_rem = {r_rem[61:0], r_rad[63:62]};
        trial = {r_root, 2'b01};
        drem_sh = {r_drem[31:0], r_dvd[55]};
        ratio = (r_job.square_sum == '0 || r_quo < 56'(ONE_Q16)) ? 56'(ONE_Q16) : r_quo;
        d = (56'(i_sqrt_n) > ratio) ? (i_sqrt_n - ratio[24:0]) : 25'd0;
        quiet = (r_job.positive_count == '0);
        sp_add = {1'b0, r_sp_acc} + 49'(r_sp);
        act_add = {1'b0, r_act_acc} + 49'(r_job.positive_count);
    end

    assign o_job_pop = (r_st == ST_IDLE) && i_job_valid;
    assign o_empty = !r_full;
    assign o_item = r_out;
    assign load_out = (r_st == ST_OUT) && !r_job.clear && (!r_full || i_pop);

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
            r_rad <= {1'b0, i_job.square_sum, 16'd0};
            r_rem <= '0;
            r_root <= '0;
            r_cnt <= '0;
        end
        case (r_st)
            ST_SQRT: begin
                r_rad <= {r_rad[61:0], 2'b00};
                if (trial_rem >= 64'(trial)) begin
                    r_rem <= trial_rem - 64'(trial);
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_rem <= trial_rem;
                    r_root <= {r_root[30:0], 1'b0};
                end
                r_cnt <= (r_cnt == 6'd31) ? '0 : r_cnt + 6'd1;
                r_dvd <= {r_job.abs_sum, 24'd0};
                r_drem <= '0;
            end
            ST_DIV: begin
                r_dvd <= {r_dvd[54:0], 1'b0};
                if (drem_sh >= {1'b0, r_root}) begin
                    r_drem <= drem_sh - {1'b0, r_root};
                    r_quo <= {r_quo[54:0], 1'b1};
                end else begin
                    r_drem <= drem_sh;
                    r_quo <= {r_quo[54:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
            end
            ST_MUL: begin
                r_prod <= 51'(d) * 51'(i_recip);
            end
            ST_TOT: begin
                r_sp <= (r_prod[50:24] > 27'(ONE_Q16)) ? ONE_Q16 : r_prod[40:24];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_full <= 1'b0;
            r_sp_acc <= '0;
            r_act_acc <= '0;
            r_q_acc <= '0;
            r_s_acc <= '0;
        end else begin
            if (load_out) begin
                r_full <= 1'b1;
            end else if (r_full && i_pop) begin
                r_full <= 1'b0;
            end
            case (r_st)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_st <= i_job.clear ? ST_OUT : ST_SQRT;
                    end
                end
                ST_SQRT: if (r_cnt == 6'd31) r_st <= ST_DIV;
                ST_DIV: if (r_cnt == 6'd55) r_st <= ST_MUL;
                ST_MUL: r_st <= ST_TOT;
                ST_TOT: r_st <= ST_OUT;
                ST_OUT: begin
                    if (r_job.clear) begin
                        r_sp_acc <= '0;
                        r_act_acc <= '0;
                        r_q_acc <= '0;
                        r_s_acc <= '0;
                        r_st <= ST_IDLE;
                    end else if (!r_full || i_pop) begin
                        r_sp_acc <= sp_add[48] ? {48{1'b1}} : sp_add[47:0];
                        r_act_acc <= act_add[48] ? {48{1'b1}} : act_add[47:0];
                        if (quiet && r_q_acc != 32'hFFFF_FFFF) r_q_acc <= r_q_acc + 32'd1;
                        if (r_s_acc != 32'hFFFF_FFFF) r_s_acc <= r_s_acc + 32'd1;
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    // Result register, loaded together with the totals.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.sample_sparsity <= r_sp;
            r_out.sample_active <= r_job.positive_count;
            r_out.sample_quiet <= quiet;
            r_out.sparsity_total <= sp_add[48] ? {48{1'b1}} : sp_add[47:0];
            r_out.active_total <= act_add[48] ? {48{1'b1}} : act_add[47:0];
            r_out.quiet_total <= (quiet && r_q_acc != 32'hFFFF_FFFF) ? r_q_acc + 32'd1 : r_q_acc;
            r_out.sample_total <= (r_s_acc != 32'hFFFF_FFFF) ? r_s_acc + 32'd1 : r_s_acc;
        end
    end
endmodule
`default_nettype wire

[sv/activation_sparsity_statistics_top.sv]
// Top level of the activation sparsity statistics block.
// Usage: Q8.8 tensor elements enter via push/full, one per cycle unless full.
// An element with last set closes a sample; a clear item zeroes the running totals.
// Each closed sample yields one result on the empty/pop side with the sample's Hoyer
// sparsity, positive count and the saturating totals after it.
// Element accumulation runs at one item per cycle unless full. The back end takes
// one sample at a time: it takes the job, runs the radix-4 square root unit, then
// the bit-serial divider, and then the multiply, the cap and the total update.
// A clear only takes the job and resets the totals.
// A queue of four jobs sits between the accumulator and the back end, so full
// rises only when samples close faster than the back end finishes them.
// When the receiver stalls, the result register holds; the back end then waits
// with the next result and the queue fills, after which full rises.
// Reset (synchronous, active low) clears all sums and totals and loads the
// register defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module activation_sparsity_statistics_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire ass_pkg::t_in_item                  i_item,
    output logic                                    empty,
    input  wire logic                               pop,
    output ass_pkg::t_out_item                      o_item,
    input  wire logic                               i_cfg_we,
    input  wire logic [ass_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [ass_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import ass_pkg::*;

    logic [16:0] r_elem_cnt;
    logic [24:0] r_sqrt_n;
    logic [25:0] r_recip;
    logic        accept, job_valid, q_full, q_empty, q_pop;
    t_job        job, q_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_cnt <= 17'd65536;
            r_sqrt_n <= 25'd16777216;
            r_recip <= 26'd65793;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ELEMENT_COUNT: r_elem_cnt <= i_cfg_data[16:0];
                REG_SQRT_OF_COUNT: r_sqrt_n <= i_cfg_data[24:0];
                REG_RECIP_SQRT: r_recip <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign full = q_full;
    assign accept = push && !full;

    ass_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(accept), .i_item(i_item),
        .o_job_valid(job_valid), .o_job(job)
    );

    ass_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(job_valid), .i_data(job),
        .o_full(q_full), .o_empty(q_empty), .i_pop(q_pop), .o_data(q_job)
    );

    ass_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_valid(!q_empty), .i_job(q_job),
        .o_job_pop(q_pop), .i_sqrt_n(r_sqrt_n), .i_recip(r_recip),
        .o_empty(empty), .i_pop(pop), .o_item(o_item)
    );

    a_spars_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_item.sample_sparsity <= ONE_Q16)
        else $error("sample sparsity above one");
    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_item.sample_quiet == (o_item.sample_active == 17'd0)))
        else $error("quiet flag disagrees with active count");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_item)))
        else $error("result changed while stalled");
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_item.quiet_total <= o_item.sample_total)
        else $error("quiet total exceeds sample total");
    a_cfg_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_elem_cnt == r_elem_cnt)
        else $error("element count register unknown");
endmodule
`default_nettype wire
